// ----- hdl/bwlp_pkg.sv -----
// shared types, constants and widths for the multichannel butterworth low-pass block
`default_nettype none

package bwlp_pkg;

	localparam int CHANNELS    = 4;
	localparam int CH_BITS     = 2;
	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_BITS   = 15;
	localparam int COEF_BITS   = 16;
	localparam int FRAC_BITS   = 14;
	localparam int CFG_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int WARM_BITS   = 2;

	localparam int TAP_BITS     = SAMPLE_BITS + 2;
	localparam int FF_PROD_BITS = COEF_BITS + TAP_BITS;
	localparam int FB_PROD_BITS = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_BITS     = FF_PROD_BITS + 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_FEEDFORWARD_GAIN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_FIRST   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_SECOND  = 2'd2;

	localparam logic [GAIN_BITS-1:0]        GAIN_RESET = 15'd723;
	localparam logic signed [COEF_BITS-1:0] FB1_RESET  = 16'sd21696;
	localparam logic signed [COEF_BITS-1:0] FB2_RESET  = -16'sd8204;

	localparam logic [WARM_BITS-1:0] WARM_EMPTY = 2'd0;
	localparam logic [WARM_BITS-1:0] WARM_HALF  = 2'd1;
	localparam logic [WARM_BITS-1:0] WARM_FULL  = 2'd2;

	typedef struct packed {
		logic [CH_BITS-1:0]            channel;
		logic signed [SAMPLE_BITS-1:0] sample;
	} sample_beat_t;

	typedef struct packed {
		logic [CH_BITS-1:0]            out_channel;
		logic signed [SAMPLE_BITS-1:0] filtered;
		logic                          primed;
	} result_beat_t;

	typedef struct packed {
		logic [WARM_BITS-1:0]          warm;
		logic signed [SAMPLE_BITS-1:0] x1;
		logic signed [SAMPLE_BITS-1:0] x2;
		logic signed [SAMPLE_BITS-1:0] y1;
		logic signed [SAMPLE_BITS-1:0] y2;
	} chan_state_t;

	localparam int STATE_BITS = $bits(chan_state_t);

endpackage

`default_nettype wire

// ----- hdl/multichannel_butterworth_lowpass.sv -----
// top level: per-channel butterworth low-pass biquad around a state ram
//
// a sample beat carries a channel and a signed sample; each one gives exactly
// one result beat with the channel, the filtered value and a primed flag.
// the first two beats of a channel only fill its input history and return
// zero with primed low. coefficients are written on the cfg port while idle;
// the block itself does not enforce this. a beat accepted passes the stage 1,
// stage 2 and stage 3 registers and then the result register. throughput:
// one beat per cycle when consecutive beats name different channels and
// result_stall does not back up the pipeline; a channel still in flight holds
// sample_stall, so its next beat waits until stage 3 writes its state back.
// reset clears all channel history through per-entry valid bits and reloads
// the default coefficients; no clearing pass is needed.
// while result_stall holds a valid result, the result register keeps it and
// the three pipeline stages fill; once they are full sample_stall rises.
`default_nettype none

module multichannel_butterworth_lowpass import bwlp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0]     cfg_data,
	input  wire logic                    sample_valid,
	output logic                         sample_stall,
	input  wire sample_beat_t            sample_data,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output result_beat_t                 result_data
);

	logic [GAIN_BITS-1:0]        gain_q;
	logic signed [COEF_BITS-1:0] fb1_q;
	logic signed [COEF_BITS-1:0] fb2_q;

	logic [CHANNELS-1:0] ent_vld_q;

	logic                          v_s1, v_s2, v_s3;
	logic [CH_BITS-1:0]            ch_s1, ch_s2, ch_s3;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          ent_vld_s1;
	logic                          primed_s2, primed_s3;
	chan_state_t                   nst_s2, nst_s3;
	logic signed [TAP_BITS-1:0]    taps_s2;

	logic                          en1, en2, en3, ld_out, hazard, accept;
	logic [STATE_BITS-1:0]         ram_rdata;
	chan_state_t                   st_s1, nst_s1, wb_state;
	logic                          primed_s1;
	logic signed [TAP_BITS-1:0]    taps_s1;
	logic signed [SAMPLE_BITS-1:0] y_s3;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			fb1_q  <= FB1_RESET;
			fb2_q  <= FB2_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FEEDFORWARD_GAIN: gain_q <= cfg_data[GAIN_BITS-1:0];
				REG_FEEDBACK_FIRST:   fb1_q  <= $signed(cfg_data[COEF_BITS-1:0]);
				REG_FEEDBACK_SECOND:  fb2_q  <= $signed(cfg_data[COEF_BITS-1:0]);
				default: ;
			endcase
		end
	end

	// pipeline flow and same-channel interlock
	always_comb begin
		ld_out = v_s3 && (!result_valid || !result_stall);
		en3    = !v_s3 || ld_out;
		en2    = !v_s2 || en3;
		en1    = !v_s1 || en2;
		hazard = (v_s1 && ch_s1 == sample_data.channel) ||
		         (v_s2 && ch_s2 == sample_data.channel) ||
		         (v_s3 && ch_s3 == sample_data.channel);
		sample_stall = !en1 || hazard;
		accept = sample_valid && !sample_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
			ent_vld_q    <= '0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (ld_out) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			if (ld_out) begin
				ent_vld_q[ch_s3] <= 1'b1;
			end
		end
	end

	bwlp_ram #(
		.WIDTH(STATE_BITS),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk  (clk),
		.we   (ld_out),
		.waddr(ch_s3),
		.wdata(wb_state),
		.re   (accept),
		.raddr(sample_data.channel),
		.rdata(ram_rdata)
	);

	// stage 1: state read, warm-up step and tap sum
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1      <= sample_data.channel;
			x_s1       <= sample_data.sample;
			ent_vld_s1 <= ent_vld_q[sample_data.channel];
		end
	end

	always_comb begin
		st_s1     = ent_vld_s1 ? chan_state_t'(ram_rdata) : '0;
		nst_s1    = st_s1;
		primed_s1 = 1'b0;
		taps_s1   = TAP_BITS'(x_s1) + (TAP_BITS'(st_s1.x1) <<< 1) + TAP_BITS'(st_s1.x2);
		priority if (st_s1.warm == WARM_EMPTY) begin
			nst_s1.x2   = x_s1;
			nst_s1.warm = WARM_HALF;
		end else if (st_s1.warm == WARM_HALF) begin
			nst_s1.x1   = x_s1;
			nst_s1.warm = WARM_FULL;
		end else begin
			nst_s1.x2 = st_s1.x1;
			nst_s1.x1 = x_s1;
			primed_s1 = 1'b1;
		end
	end

	// stage 2 and stage 3 registers; bwlp_mac forms the products from stage 2
	always_ff @(posedge clk) begin
		if (en2) begin
			ch_s2     <= ch_s1;
			primed_s2 <= primed_s1;
			nst_s2    <= nst_s1;
			taps_s2   <= taps_s1;
		end
		if (en3) begin
			ch_s3     <= ch_s2;
			primed_s3 <= primed_s2;
			nst_s3    <= nst_s2;
		end
	end

	bwlp_mac u_mac (
		.clk (clk),
		.en  (en3),
		.taps(taps_s2),
		.y1  (nst_s2.y1),
		.y2  (nst_s2.y2),
		.gain(gain_q),
		.fb1 (fb1_q),
		.fb2 (fb2_q),
		.y   (y_s3)
	);

	// stage 3: write back and result register
	always_comb begin
		wb_state = nst_s3;
		if (primed_s3) begin
			wb_state.y2 = nst_s3.y1;
			wb_state.y1 = y_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			result_data.out_channel <= ch_s3;
			result_data.filtered    <= primed_s3 ? y_s3 : '0;
			result_data.primed      <= primed_s3;
		end
	end

	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && accept |-> ch_s3 != sample_data.channel)
		else $error("state ram read and written at the same entry");

	a_stage_channels_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		!((v_s1 && v_s2 && ch_s1 == ch_s2) || (v_s1 && v_s3 && ch_s1 == ch_s3) ||
		  (v_s2 && v_s3 && ch_s2 == ch_s3)))
		else $error("one channel in two pipeline stages");

	a_entry_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> ent_vld_q[$past(ch_s3)])
		else $error("entry valid bit not set after write back");

	a_warmup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.primed |-> result_data.filtered == '0)
		else $error("nonzero result while not primed");

endmodule

`default_nettype wire

// ----- hdl/bwlp_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module bwlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bwlp_mac.sv -----
// biquad multiply stage with registered products, sum, rounding and saturation
`default_nettype none

module bwlp_mac import bwlp_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [TAP_BITS-1:0]    taps,
	input  wire logic signed [SAMPLE_BITS-1:0] y1,
	input  wire logic signed [SAMPLE_BITS-1:0] y2,
	input  wire logic [GAIN_BITS-1:0]          gain,
	input  wire logic signed [COEF_BITS-1:0]   fb1,
	input  wire logic signed [COEF_BITS-1:0]   fb2,
	output logic signed [SAMPLE_BITS-1:0]      y
);

	localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_BITS-1:0] SAT_HI =
		(ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

	logic signed [FF_PROD_BITS-1:0] ff_s3;
	logic signed [FB_PROD_BITS-1:0] fb1_s3;
	logic signed [FB_PROD_BITS-1:0] fb2_s3;
	logic signed [COEF_BITS-1:0]    gain_sx;
	logic signed [ACC_BITS-1:0]     acc;
	logic signed [ACC_BITS-1:0]     shifted;

	assign gain_sx = $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (en) begin
			ff_s3  <= gain_sx * taps;
			fb1_s3 <= fb1 * y1;
			fb2_s3 <= fb2 * y2;
		end
	end

	always_comb begin
		acc = ACC_BITS'(ff_s3) + ACC_BITS'(fb1_s3) + ACC_BITS'(fb2_s3) + ROUND_BIAS;
		shifted = acc >>> FRAC_BITS;
		if (shifted > SAT_HI) begin
			y = SAT_HI[SAMPLE_BITS-1:0];
		end else if (shifted < SAT_LO) begin
			y = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			y = shifted[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire
